### rtl/panned_playback_fifo_with_volume_ramp_unit_defines.svh
// Assertion macros for the panned playback FIFO checker.
// No dependencies.
`ifndef PANNED_PLAYBACK_FIFO_WITH_VOLUME_RAMP_UNIT_DEFINES_SVH
`define PANNED_PLAYBACK_FIFO_WITH_VOLUME_RAMP_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PPF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define PPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/ppf_pkg.sv
// Shared types and constants for the panned playback FIFO.
// No dependencies.
package ppf_pkg;
	localparam int QUEUE_PAIRS = 2048;
	localparam int IDX_W = $clog2(QUEUE_PAIRS);
	localparam int FILL_W = $clog2(QUEUE_PAIRS + 1);
	localparam logic [15:0] UNITY_Q15 = 16'd32768;
	localparam logic [13:0] RAMP_Q16 = 14'd11796;
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_PULL = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic CFG_MASTER = 1'b0;
	localparam logic CFG_SMOOTH = 1'b1;
	typedef struct packed {
		logic [15:0] pan;
		logic [15:0] gain;
		logic [15:0] mono_sample;
	} in_data_t;
	typedef struct packed {
		logic [31:0] played_total;
		logic [15:0] out_sample;
	} out_data_t;
endpackage

### rtl/panned_playback_fifo_with_volume_ramp_unit.sv
// Panned playback FIFO with volume ramp: top level.
// Depends on ppf_pkg.
//
// Input stream s_axis: tuser = command (0 push, 1 tick, 2 pull, 3 ignored),
// tdata from bit 0: mono_sample, gain, pan. Only a pull produces an output
// transaction on m_axis: tdata from bit 0: out_sample, played_total;
// tuser = from_queue.
// A push runs one shared bit-serial square root per pan factor, then four
// passes through one shared 33x16 multiplier and a store; the next item is
// taken after the store. A tick passes through ST_TICK1 and ST_TICK2. A pull
// passes through ST_RD, ST_RDW, ST_PMUL and ST_OUT, then presents its result;
// the next item is taken once it is accepted. An ignored command has no effect.
// s_axis_tready is low while an item is in work or a result waits.
// A stalled m_axis holds its result and keeps the input stalled.
// Reset clears pointers, fill level, volume to unity, counter to zero.
// The pair store has no reset; entries are only read after being written.
// Configuration: cfg_we, cfg_index (0 master_volume, 1 smoothing_enable),
// cfg_wdata, to be written only while idle; the block does not enforce this.
module panned_playback_fifo_with_volume_ramp_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // mono_sample, gain, pan
	input  logic [1:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_sample, played_total
	output logic        m_axis_tuser,  // from_queue
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import ppf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROOT, ST_MLA, ST_MLB, ST_MRA, ST_MRB, ST_STORE, ST_TICK1, ST_TICK2,
		ST_RD, ST_RDW, ST_PMUL, ST_OUT
	} state_t;

	state_t state_q;
	in_data_t in_q;
	logic [31:0] mem_q [QUEUE_PAIRS];
	logic [31:0] rd_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [FILL_W-1:0] fill_q;
	logic rhalf_q;
	logic [15:0] vol_q, master_q;
	logic smooth_q;
	logic [31:0] played_q;
	logic valid_q;
	out_data_t out_q;
	logic fromq_q;
	// sqrt unit
	logic [31:0] rv_q, rr_q, rbit_q;
	logic side_q;
	logic [15:0] lf_q, rf_q;
	logic [4:0] cnt_q;
	// multiplier
	logic [32:0] mul_a;
	logic [15:0] mul_b;
	logic [48:0] prod;
	logic [32:0] pm_q;
	logic [15:0] l_q, r_q;
	logic [16:0] mag_q;
	logic neg_q;
	logic [31:0] d_q;
	logic up_q;

	assign s_axis_tready = (state_q == ST_IDLE) && !valid_q;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = out_q;
	assign m_axis_tuser = fromq_q;

	logic signed [16:0] panx, aval;
	logic [15:0] afact;
	always_comb begin
		panx = {in_q.pan[15], in_q.pan};
		aval = side_q ? 17'sd16384 + panx : 17'sd16384 - panx;
		if (aval < 0) afact = '0;
		else if (aval > 17'sd32768) afact = 16'd32768;
		else afact = aval[15:0];
	end

	assign prod = mul_a * mul_b;

	function automatic logic [15:0] sat16(input logic neg, input logic [48:0] q);
		logic [15:0] r;
		if (neg) r = (q > 49'd32768) ? 16'h8000 : 16'(17'h10000 - q[16:0]);
		else r = (q > 49'd32767) ? 16'h7fff : q[15:0];
		return r;
	endfunction

	logic [48:0] q27, q15;
	logic [15:0] ch_val;
	assign q27 = prod >> 27;
	assign q15 = prod >> 15;
	assign ch_val = sat16(neg_q, q27);

	logic [31:0] sum_rb;
	assign sum_rb = rr_q + rbit_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MLA: begin mul_a = 33'(mag_q); mul_b = lf_q; end
			ST_MLB: begin mul_a = pm_q; mul_b = in_q.gain; end
			ST_MRA: begin mul_a = 33'(mag_q); mul_b = rf_q; end
			ST_MRB: begin mul_a = pm_q; mul_b = in_q.gain; end
			ST_PMUL: begin mul_a = 33'(mag_q); mul_b = vol_q; end
			ST_TICK1: begin mul_a = 33'(d_q); mul_b = 16'(RAMP_Q16); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STORE) mem_q[head_q] <= {r_q, l_q};
		rd_q <= mem_q[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0; tail_q <= '0; fill_q <= '0; rhalf_q <= 1'b0;
			vol_q <= UNITY_Q15; master_q <= UNITY_Q15; smooth_q <= 1'b1;
			played_q <= '0; valid_q <= 1'b0;
		end else begin
			if (valid_q && m_axis_tready) valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_MASTER) begin
					master_q <= (cfg_wdata > UNITY_Q15) ? UNITY_Q15 : cfg_wdata;
					if (!smooth_q) vol_q <= (cfg_wdata > UNITY_Q15) ? UNITY_Q15 : cfg_wdata;
				end else begin
					smooth_q <= cfg_wdata[0];
					if (!cfg_wdata[0]) vol_q <= master_q;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						in_q <= s_axis_tdata;
						case (s_axis_tuser)
							CMD_PUSH: begin
								state_q <= ST_ROOT; side_q <= 1'b0; cnt_q <= '0;
							end
							CMD_TICK: begin
								up_q <= master_q > vol_q;
								d_q <= (master_q > vol_q) ? 32'(master_q - vol_q)
									: 32'(vol_q - master_q);
								state_q <= ST_TICK1;
							end
							CMD_PULL: state_q <= ST_RD;
							default: ;
						endcase
					end
				end
				ST_ROOT: begin
					if (cnt_q == 5'd0) begin
						rv_q <= {1'b0, afact, 15'd0};
						rr_q <= '0;
						rbit_q <= 32'h4000_0000;
						cnt_q <= 5'd1;
					end else if (rbit_q != 0) begin
						if (rv_q >= sum_rb) begin
							rv_q <= rv_q - sum_rb;
							rr_q <= (rr_q >> 1) + rbit_q;
						end else rr_q <= rr_q >> 1;
						rbit_q <= rbit_q >> 2;
					end else begin
						cnt_q <= '0;
						if (!side_q) begin
							lf_q <= rr_q[15:0] | {rr_q[16], 15'd0};
							side_q <= 1'b1;
						end else begin
							rf_q <= rr_q[15:0] | {rr_q[16], 15'd0};
							neg_q <= in_q.mono_sample[15];
							mag_q <= in_q.mono_sample[15] ? 17'(-{1'b1, in_q.mono_sample})
								: {1'b0, in_q.mono_sample};
							state_q <= ST_MLA;
						end
					end
				end
				ST_MLA: begin pm_q <= prod[32:0]; state_q <= ST_MLB; end
				ST_MLB: begin l_q <= ch_val; state_q <= ST_MRA; end
				ST_MRA: begin pm_q <= prod[32:0]; state_q <= ST_MRB; end
				ST_MRB: begin r_q <= ch_val; state_q <= ST_STORE; end
				ST_STORE: begin
					if (fill_q == FILL_W'(QUEUE_PAIRS)) begin
						tail_q <= (tail_q == IDX_W'(QUEUE_PAIRS - 1)) ? '0 : tail_q + 1'b1;
						rhalf_q <= 1'b0;
					end else fill_q <= fill_q + 1'b1;
					head_q <= (head_q == IDX_W'(QUEUE_PAIRS - 1)) ? '0 : head_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_TICK1: begin
					d_q <= 32'((prod[31:0] + 32'd32768) >> 16);
					state_q <= ST_TICK2;
				end
				ST_TICK2: begin
					if (!smooth_q) vol_q <= master_q;
					else if (master_q != vol_q) begin
						if (up_q) vol_q <= vol_q + ((d_q == 0) ? 16'd1 : d_q[15:0]);
						else vol_q <= vol_q - ((d_q == 0) ? 16'd1 : d_q[15:0]);
					end
					state_q <= ST_IDLE;
				end
				ST_RD: state_q <= ST_RDW;
				ST_RDW: begin
					neg_q <= rhalf_q ? rd_q[31] : rd_q[15];
					mag_q <= rhalf_q ? (rd_q[31] ? 17'(-{1'b1, rd_q[31:16]}) : {1'b0, rd_q[31:16]})
						: (rd_q[15] ? 17'(-{1'b1, rd_q[15:0]}) : {1'b0, rd_q[15:0]});
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					if (fill_q == 0) begin
						out_q.out_sample <= '0;
						fromq_q <= 1'b0;
						out_q.played_total <= played_q;
					end else begin
						out_q.out_sample <= sat16(neg_q, q15);
						fromq_q <= 1'b1;
						out_q.played_total <= played_q + 1'b1;
						played_q <= played_q + 1'b1;
						if (rhalf_q) begin
							tail_q <= (tail_q == IDX_W'(QUEUE_PAIRS - 1)) ? '0 : tail_q + 1'b1;
							fill_q <= fill_q - 1'b1;
							rhalf_q <= 1'b0;
						end else rhalf_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/ppf_checker.sv
// Port-level checker for the panned playback FIFO, with its bind.
// Depends on the defines header and ppf_pkg.
`include "panned_playback_fifo_with_volume_ramp_unit_defines.svh"
module ppf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	import ppf_pkg::*;

	`PPF_ASSERT_IMPL(a_no_accept_while_out, m_axis_tvalid, !s_axis_tready)
	`PPF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`PPF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_UNUSED, !s_axis_tready)
	`PPF_ASSERT_IMPL(a_zero_fill, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == 16'd0)
endmodule

bind panned_playback_fifo_with_volume_ramp_unit ppf_checker u_ppf_checker (.*);

### bench/panned_playback_fifo_with_volume_ramp_unit_tb.sv
// Self-checking bench for the panned playback FIFO with volume ramp: stream driver,
// result monitor and a transaction-level predictor of the pan, FIFO and volume logic.
// Depends on ppf_pkg and panned_playback_fifo_with_volume_ramp_unit.
module panned_playback_fifo_with_volume_ramp_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppf_pkg::*;

	localparam int QUIET_CYCLES = 80;
	localparam int STALL_LIMIT = 20000;

	typedef enum {ITEM_DATA, ITEM_CFG, ITEM_DRAIN} item_kind_t;
	typedef struct {
		item_kind_t kind;
		logic [1:0] cmd;
		in_data_t data;
		logic cfg_idx;
		logic [15:0] cfg_val;
	} pending_t;
	typedef struct {
		logic [15:0] sample;
		logic from_q;
		logic [31:0] total;
	} playback_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [15:0] cfg_wdata = '0;

	panned_playback_fifo_with_volume_ramp_unit dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	pending_t pending_items[$];
	playback_t playback_expected[$];
	int errors = 0;

	// predictor state
	logic [31:0] pair_mem [QUEUE_PAIRS];
	int head_q = 0, tail_q = 0, fill_q = 0;
	bit right_next = 0;
	int unsigned volume_q = 32768, master_q = 32768, played_q = 0;
	bit smooth_q = 1;

	function automatic int unsigned isqrt(int unsigned v);
		int unsigned r, b;
		r = 0;
		b = 1 << 30;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] sat16(longint q);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic int unsigned pan_gain(int a);
		if (a < 0) a = 0;
		if (a > 32768) a = 32768;
		return isqrt(a << 15);
	endfunction

	function automatic void apply_cfg(logic idx, logic [15:0] val);
		if (idx == CFG_MASTER) master_q = (val > 32768) ? 32768 : val;
		else smooth_q = val[0];
		if (!smooth_q) volume_q = master_q;
	endfunction

	function automatic void predict(logic [1:0] cmd, in_data_t d);
		longint s, g, q;
		int p;
		int unsigned lf, rf, diff, step;
		logic [15:0] l, r, half;
		playback_t e;
		case (cmd)
			CMD_PUSH: begin
				s = $signed(d.mono_sample);
				g = d.gain;
				p = $signed(d.pan);
				lf = pan_gain(16384 - p);
				rf = pan_gain(16384 + p);
				l = sat16((s * longint'(lf) * g) / (longint'(1) <<< 27));
				r = sat16((s * longint'(rf) * g) / (longint'(1) <<< 27));
				if (fill_q >= QUEUE_PAIRS) begin
					tail_q = (tail_q + 1) % QUEUE_PAIRS;
					fill_q--;
					right_next = 0;
				end
				pair_mem[head_q] = {r, l};
				head_q = (head_q + 1) % QUEUE_PAIRS;
				fill_q++;
			end
			CMD_TICK: begin
				if (!smooth_q) begin
					volume_q = master_q;
				end else if (master_q != volume_q) begin
					diff = (master_q > volume_q) ? master_q - volume_q : volume_q - master_q;
					step = (diff * 11796 + 32768) >> 16;
					if (step == 0) step = 1;
					volume_q = (master_q > volume_q) ? volume_q + step : volume_q - step;
				end
			end
			CMD_PULL: begin
				if (fill_q == 0) begin
					e.sample = '0;
					e.from_q = 0;
				end else begin
					half = right_next ? pair_mem[tail_q][31:16] : pair_mem[tail_q][15:0];
					q = longint'($signed(half)) * longint'(volume_q);
					e.sample = sat16(q / 32768);
					e.from_q = 1;
					played_q++;
					if (right_next) begin
						tail_q = (tail_q + 1) % QUEUE_PAIRS;
						fill_q--;
						right_next = 0;
					end else begin
						right_next = 1;
					end
				end
				e.total = played_q;
				playback_expected.insert(playback_expected.size(), e);
			end
			default: ;
		endcase
	endfunction

	// driver
	int burst_left = 0, gap_left = 0, quiet_cnt = 0;
	always @(posedge clk) begin
		logic valid_n;
		logic we_n;
		valid_n = s_axis_tvalid;
		we_n = 0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict(pending_items[0].cmd, pending_items[0].data);
				void'(pending_items.pop_front());
				valid_n = 0;
			end
			quiet_cnt = (playback_expected.size() == 0 && !s_axis_tvalid) ? quiet_cnt + 1 : 0;
			if (!valid_n && pending_items.size() > 0) begin
				case (pending_items[0].kind)
					ITEM_CFG: if (playback_expected.size() == 0 && quiet_cnt > QUIET_CYCLES) begin
						we_n = 1;
						cfg_index <= pending_items[0].cfg_idx;
						cfg_wdata <= pending_items[0].cfg_val;
						apply_cfg(pending_items[0].cfg_idx, pending_items[0].cfg_val);
						void'(pending_items.pop_front());
					end
					ITEM_DRAIN: if (playback_expected.size() == 0 && quiet_cnt > QUIET_CYCLES)
						void'(pending_items.pop_front());
					default: if (gap_left > 0) begin
						gap_left--;
					end else begin
						valid_n = 1;
						s_axis_tuser <= pending_items[0].cmd;
						s_axis_tdata <= pending_items[0].data;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 20);
							gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
						end
					end
				endcase
			end
		end
		s_axis_tvalid <= valid_n;
		cfg_we <= we_n;
	end

	// monitor and receiver stall pattern
	int results_seen = 0, hold_left = 0, mode_cnt = 0, rx_mode = 0;
	bit long_hold_done = 0;
	always @(posedge clk) begin
		out_data_t got;
		playback_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				results_seen++;
				if (playback_expected.size() == 0) begin
					$error("unexpected output transaction");
					errors++;
				end else begin
					e = playback_expected.pop_front();
					if (got.out_sample !== e.sample) begin
						$error("out_sample expected %0d actual %0d",
							$signed(e.sample), $signed(got.out_sample));
						errors++;
					end
					if (m_axis_tuser !== e.from_q) begin
						$error("from_queue expected %0d actual %0d", e.from_q, m_axis_tuser);
						errors++;
					end
					if (got.played_total !== e.total) begin
						$error("played_total expected %0d actual %0d", e.total, got.played_total);
						errors++;
					end
				end
			end
			if (!long_hold_done && results_seen == 300) begin
				long_hold_done = 1;
				hold_left = 3000;
			end
			if (++mode_cnt >= 200) begin
				mode_cnt = 0;
				rx_mode = $urandom_range(0, 2);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 0;
			end else begin
				case (rx_mode)
					0: m_axis_tready <= 1;
					1: m_axis_tready <= $urandom_range(0, 1);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transaction
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_item(logic [1:0] cmd, int unsigned smp, int unsigned g, int unsigned p);
		pending_t it;
		it.kind = ITEM_DATA;
		it.cmd = cmd;
		it.data.mono_sample = 16'(smp);
		it.data.gain = 16'(g);
		it.data.pan = 16'(p);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_ctl(item_kind_t k, logic idx, logic [15:0] val);
		pending_t it;
		it.kind = k;
		it.cmd = CMD_UNUSED;
		it.data = '0;
		it.cfg_idx = idx;
		it.cfg_val = val;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_random(int n);
		int r;
		logic [15:0] p;
		repeat (n) begin
			r = $urandom_range(0, 99);
			p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
			if (r < 42) add_item(CMD_PUSH, $urandom, $urandom, p);
			else if (r < 88) add_item(CMD_PULL, $urandom, $urandom, $urandom);
			else if (r < 96) add_item(CMD_TICK, $urandom, $urandom, $urandom);
			else add_item(CMD_UNUSED, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		// directed: extremes, underrun, every command, clamped pan
		add_item(CMD_PULL, 0, 0, 0);
		add_item(CMD_PUSH, 16'h7fff, 16'hffff, 16'd0);
		add_item(CMD_PUSH, 16'h8000, 16'hffff, -16'sd16384);
		add_item(CMD_PUSH, 16'h8000, 16'hffff, 16'sd16384);
		add_item(CMD_PUSH, 16'h1234, 16'h0000, 16'h8000);
		add_item(CMD_PUSH, 16'hedcb, 16'h1000, 16'h7fff);
		add_item(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff);
		repeat (12) add_item(CMD_PULL, 0, 0, 0);
		add_ctl(ITEM_CFG, CFG_MASTER, 16'hffff);
		add_ctl(ITEM_CFG, CFG_MASTER, 16'd0);
		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_PUSH, 16'h7fff, 16'h1000, 0);
		add_item(CMD_PULL, 0, 0, 0);
		add_ctl(ITEM_CFG, CFG_SMOOTH, 16'd0);
		add_ctl(ITEM_CFG, CFG_MASTER, 16'd32768);
		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_PULL, 0, 0, 0);
		add_ctl(ITEM_CFG, CFG_SMOOTH, 16'hffff);
		// random phases with settings changed in between
		for (int ph = 0; ph < 7; ph++) begin
			add_random(120);
			add_ctl(ITEM_DRAIN, CFG_MASTER, 16'd0);
			add_ctl(ITEM_CFG, CFG_MASTER, (ph % 3 == 0) ? 16'd0 : 16'($urandom));
			add_ctl(ITEM_CFG, CFG_SMOOTH, 16'($urandom));
			repeat (15) add_item(CMD_TICK, 0, 0, 0);
		end
		add_random(80);

		repeat (2) @(posedge clk);
		arst_n <= 1;
		while (pending_items.size() > 0 || playback_expected.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && playback_expected.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
